>>> sv/rasst_pkg.sv
`default_nettype none
// ============================================================================
// rasst_pkg
// Shared types and constants for the range-add / range-sum tree.
// ============================================================================
package rasst_pkg;

    // Default number of array positions the tree is sized for.
    localparam int DEF_MAX_POSITIONS = 65536;

    // Fixed field widths of the streaming payload.
    localparam int SUM_W    = 64;
    localparam int FIELD_W  = 17;
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int IN_DATA_W = 72;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Progress of one tree node during the descent.
    typedef enum logic [1:0] {
        PH_ENTER = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2
    } phase_t;

    // One memory entry: pending add and interval sum of a node.
    typedef struct packed {
        logic [SUM_W-1:0] pend;
        logic [SUM_W-1:0] sum;
    } node_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_LEAF,
        ST_LEAF_WR,
        ST_PD_K,
        ST_PD_C0,
        ST_C0_WR,
        ST_PD_C1,
        ST_C1_WR,
        ST_PD_WR,
        ST_SUM0,
        ST_SUM1,
        ST_MUL,
        ST_RET,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

>>> sv/range_add_range_sum_tree.sv
`default_nettype none
// ============================================================================
// range_add_range_sum_tree
// Lazy segment tree over signed 64-bit counters with range add and range sum.
// ============================================================================
// One operation is handled at a time. The tree lives in a single node memory
// of 2^(clog2(MAX_POSITIONS)+1) entries (131072 at the default size), and a
// sequencer walks it depth first with a small stack of parent nodes. After
// reset, and for every clear operation, a clearing pass writes zero to that
// many entries, one per cycle, while no transaction is accepted. Rejected,
// empty and unused operations go straight to the response. An add or query
// visits and returns at each node it passes through; on top of that every
// node whose pending add is pushed to its children reads and writes both
// children through the multiplier, every node whose sum is rebuilt after an
// add reads both children, and every node that an add covers whole takes a
// multiply. The one memory read port and the registered multiplier set the
// pace of an operation. The next transaction is taken while the previous
// result still waits.
module range_add_range_sum_tree #(
    parameter int MAX_POSITIONS = rasst_pkg::DEF_MAX_POSITIONS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: size_in_use.
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // range_left[16:0], range_right[33:17],
                                        // add_value[65:34], zero pad
    input  wire logic [1:0]  s_tuser,   // operation
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // range_sum
    output logic             m_tuser    // status
);
    import rasst_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POSITIONS) + 1;
    localparam int POS_W  = $clog2(MAX_POSITIONS + 1);
    localparam int CW     = (POS_W > FIELD_W) ? POS_W : FIELD_W;
    localparam int STK_D  = ADDR_W;
    localparam int IDX_W  = $clog2(STK_D);
    localparam int SP_W   = $clog2(STK_D + 1);

    state_t state_reg, state_next, ret_reg;

    logic [16:0]        size_reg;
    op_t                op_reg;
    logic [63:0]        v_reg;
    logic [63:0]        acc_reg;
    logic               stat_reg;
    logic               clr_resp_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    // Current frame.
    logic [ADDR_W-1:0]  k_reg;
    logic [POS_W-1:0]   lo_reg, hi_reg, a_reg, b_reg;
    phase_t             ph_reg;

    // Parent stack.
    logic [ADDR_W-1:0]  stk_k   [STK_D];
    logic [POS_W-1:0]   stk_lo  [STK_D];
    logic [POS_W-1:0]   stk_hi  [STK_D];
    logic [POS_W-1:0]   stk_a   [STK_D];
    logic [POS_W-1:0]   stk_b   [STK_D];
    phase_t             stk_ph  [STK_D];
    logic [SP_W-1:0]    sp_reg;

    // Read-modify-write holding registers.
    logic [63:0]        padd_reg, ksum_reg, s0_reg;
    node_t              ent_reg;
    logic [63:0]        mop_reg;
    logic [POS_W-1:0]   mlen_reg;

    // Output register.
    logic               out_valid_reg;
    logic [63:0]        out_sum_reg;
    logic               out_status_reg;

    // Memory and multiplier connections.
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    node_t              wr_data, rd_data;
    logic [63:0]        prod;

    rasst_mem #(.ADDR_W(ADDR_W)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rasst_mul #(.LEN_W(POS_W)) u_mul (
        .clk  (clk),
        .opnd (mop_reg),
        .len  (mlen_reg),
        .prod (prod)
    );

    // Input fields.
    op_t               in_op;
    logic [CW-1:0]     in_a, in_b, n_clamp;
    logic [63:0]       in_v;
    logic              s_acc;

    assign in_op = op_t'(s_tuser);
    assign in_a  = CW'(s_tdata[16:0]);
    assign in_b  = CW'(s_tdata[33:17]);
    assign in_v  = {{32{s_tdata[65]}}, s_tdata[65:34]};
    assign s_acc = s_tvalid && s_tready;

    // Positions in use, clamped to 1..MAX_POSITIONS.
    always_comb
    begin
        if (size_reg == 17'd0)
        begin
            n_clamp = CW'(1);
        end
        else if (CW'(size_reg) > CW'(MAX_POSITIONS))
        begin
            n_clamp = CW'(MAX_POSITIONS);
        end
        else
        begin
            n_clamp = CW'(size_reg);
        end
    end

    // Split point and child frames of the current node.
    logic [POS_W:0]     mid_sum;
    logic [POS_W-1:0]   mid, mid_p1;
    logic [ADDR_W-1:0]  k0, k1;
    logic [POS_W-1:0]   len_all, len_left, len_right;
    logic [POS_W-1:0]   lb, ra;

    assign mid_sum   = (POS_W+1)'(lo_reg) + (POS_W+1)'(hi_reg);
    assign mid       = mid_sum[POS_W:1];
    assign mid_p1    = POS_W'(mid + 1'b1);
    assign k0        = {k_reg[ADDR_W-2:0], 1'b0};
    assign k1        = {k_reg[ADDR_W-2:0], 1'b1};
    assign len_all   = POS_W'(hi_reg - lo_reg + 1'b1);
    assign len_left  = POS_W'(mid - lo_reg + 1'b1);
    assign len_right = POS_W'(hi_reg - mid);
    assign lb        = (b_reg < mid) ? b_reg : mid;
    assign ra        = (a_reg > mid_p1) ? a_reg : mid_p1;

    logic exact, empty_rng;
    assign exact     = (lo_reg == a_reg) && (hi_reg == b_reg);
    assign empty_rng = a_reg > b_reg;

    logic [IDX_W-1:0] top_idx, push_idx;
    assign push_idx = sp_reg[IDX_W-1:0];
    assign top_idx  = IDX_W'(sp_reg - 1'b1);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and memory control.
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = k_reg;
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                if (&clr_cnt_reg)
                begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_acc)
                begin
                    if (in_op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (in_op == OP_NONE || in_a > in_b || in_a == '0
                             || in_b > n_clamp)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_VISIT;
                    end
                end
            end
            ST_VISIT:
            begin
                if (empty_rng)
                begin
                    state_next = ST_RET;
                end
                else if (exact)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LEAF;
                end
                else
                begin
                    unique case (ph_reg)
                        PH_ENTER:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_PD_K;
                        end
                        PH_LEFT:
                        begin
                            state_next = ST_VISIT;
                        end
                        PH_RIGHT:
                        begin
                            if (op_reg == OP_ADD)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = k0;
                                state_next = ST_SUM0;
                            end
                            else
                            begin
                                state_next = ST_RET;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RET;
                        end
                    endcase
                end
            end
            ST_LEAF:
            begin
                state_next = (op_reg == OP_ADD) ? ST_MUL : ST_RET;
            end
            ST_LEAF_WR:
            begin
                wr_en        = 1'b1;
                wr_data.pend = ent_reg.pend + v_reg;
                wr_data.sum  = ent_reg.sum + prod;
                state_next   = ST_RET;
            end
            ST_PD_K:
            begin
                rd_en      = 1'b1;
                rd_addr    = k0;
                state_next = ST_PD_C0;
            end
            ST_PD_C0:
            begin
                state_next = ST_MUL;
            end
            ST_C0_WR:
            begin
                wr_en        = 1'b1;
                wr_addr      = k0;
                wr_data.pend = ent_reg.pend + padd_reg;
                wr_data.sum  = ent_reg.sum + prod;
                rd_en        = 1'b1;
                rd_addr      = k1;
                state_next   = ST_PD_C1;
            end
            ST_PD_C1:
            begin
                state_next = ST_MUL;
            end
            ST_C1_WR:
            begin
                wr_en        = 1'b1;
                wr_addr      = k1;
                wr_data.pend = ent_reg.pend + padd_reg;
                wr_data.sum  = ent_reg.sum + prod;
                state_next   = ST_PD_WR;
            end
            ST_PD_WR:
            begin
                wr_en       = 1'b1;
                wr_data.sum = ksum_reg;
                state_next  = ST_VISIT;
            end
            ST_SUM0:
            begin
                rd_en      = 1'b1;
                rd_addr    = k1;
                state_next = ST_SUM1;
            end
            ST_SUM1:
            begin
                wr_en       = 1'b1;
                wr_data.sum = s0_reg + rd_data.sum;
                state_next  = ST_RET;
            end
            ST_MUL:
            begin
                state_next = ret_reg;
            end
            ST_RET:
            begin
                state_next = (sp_reg == '0) ? ST_RESP : ST_VISIT;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= 17'd65536;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    clr_cnt_reg  <= '0;
                    clr_resp_reg <= 1'b1;
                    sp_reg       <= '0;
                end
                ST_VISIT:
                begin
                    if (!empty_rng && !exact && ph_reg == PH_LEFT)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                end
                ST_PD_WR:
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
                ST_RET:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_reg - 1'b1;
                    end
                end
                ST_RESP:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg   <= in_op;
                v_reg    <= in_v;
                acc_reg  <= '0;
                stat_reg <= (in_op == OP_ADD || in_op == OP_QUERY) && !(in_a > in_b)
                            && (in_a == '0 || in_b > n_clamp);
                k_reg    <= ADDR_W'(1);
                lo_reg   <= POS_W'(1);
                hi_reg   <= POS_W'(n_clamp);
                a_reg    <= POS_W'(in_a);
                b_reg    <= POS_W'(in_b);
                ph_reg   <= PH_ENTER;
            end
            ST_VISIT:
            begin
                // Left subtree finished: save this node and go right.
                if (!empty_rng && !exact && ph_reg == PH_LEFT)
                begin
                    stk_k[push_idx]  <= k_reg;
                    stk_lo[push_idx] <= lo_reg;
                    stk_hi[push_idx] <= hi_reg;
                    stk_a[push_idx]  <= a_reg;
                    stk_b[push_idx]  <= b_reg;
                    stk_ph[push_idx] <= PH_RIGHT;
                    k_reg  <= k1;
                    lo_reg <= mid_p1;
                    a_reg  <= ra;
                    ph_reg <= PH_ENTER;
                end
            end
            ST_LEAF:
            begin
                ent_reg  <= rd_data;
                mop_reg  <= v_reg;
                mlen_reg <= len_all;
                ret_reg  <= ST_LEAF_WR;
                if (op_reg == OP_QUERY)
                begin
                    acc_reg <= acc_reg + rd_data.sum;
                end
            end
            ST_PD_K:
            begin
                padd_reg <= rd_data.pend;
                ksum_reg <= rd_data.sum;
            end
            ST_PD_C0:
            begin
                ent_reg  <= rd_data;
                mop_reg  <= padd_reg;
                mlen_reg <= len_left;
                ret_reg  <= ST_C0_WR;
            end
            ST_PD_C1:
            begin
                ent_reg  <= rd_data;
                mlen_reg <= len_right;
                ret_reg  <= ST_C1_WR;
            end
            ST_PD_WR:
            begin
                // Push-down done: save this node and descend left.
                stk_k[push_idx]  <= k_reg;
                stk_lo[push_idx] <= lo_reg;
                stk_hi[push_idx] <= hi_reg;
                stk_a[push_idx]  <= a_reg;
                stk_b[push_idx]  <= b_reg;
                stk_ph[push_idx] <= PH_LEFT;
                k_reg  <= k0;
                hi_reg <= mid;
                b_reg  <= lb;
                ph_reg <= PH_ENTER;
            end
            ST_SUM0:
            begin
                s0_reg <= rd_data.sum;
            end
            ST_RET:
            begin
                if (sp_reg != '0)
                begin
                    k_reg  <= stk_k[top_idx];
                    lo_reg <= stk_lo[top_idx];
                    hi_reg <= stk_hi[top_idx];
                    a_reg  <= stk_a[top_idx];
                    b_reg  <= stk_b[top_idx];
                    ph_reg <= stk_ph[top_idx];
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_sum_reg    <= stat_reg ? 64'd0 : acc_reg;
                    out_status_reg <= stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_status_reg;

endmodule
`default_nettype wire

>>> sv/rasst_mem.sv
`default_nettype none
// ============================================================================
// rasst_mem
// Node memory: one write port and one read port, registered read data.
// ============================================================================
module rasst_mem #(
    parameter int ADDR_W = 17
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire rasst_pkg::node_t      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output rasst_pkg::node_t           rd_data
);
    import rasst_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    node_t mem [DEPTH];
    node_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: data appears in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> sv/rasst_mul.sv
`default_nettype none
// ============================================================================
// rasst_mul
// Registered 64 by LEN_W multiplier, modulo 2^64, split in two 32-bit halves.
// ============================================================================
module rasst_mul #(
    parameter int LEN_W = 17
) (
    input  wire logic              clk,
    input  wire logic [63:0]       opnd,
    input  wire logic [LEN_W-1:0]  len,
    output logic      [63:0]       prod
);
    logic [32+LEN_W-1:0] plo_reg;
    logic [31:0]         phi_reg;
    logic [32+LEN_W-1:0] phi_full;

    // Upper half only contributes its low 32 bits modulo 2^64.
    assign phi_full = opnd[63:32] * len;

    always_ff @(posedge clk)
    begin
        plo_reg <= opnd[31:0] * len;
        phi_reg <= phi_full[31:0];
    end

    // Recombine the partial products.
    assign prod = 64'(plo_reg) + {phi_reg, 32'd0};

endmodule
`default_nettype wire

>>> sv/rasst_chk.sv
`default_nettype none
// ============================================================================
// rasst_chk
// Port-level checks for the range-add / range-sum tree.
// ============================================================================
module rasst_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);
    // A stalled result holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A rejected operation reports a zero sum.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("rejected operation with nonzero sum");

    // Only one operation is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

endmodule

bind range_add_range_sum_tree rasst_chk u_rasst_chk (.*);
`default_nettype wire
